>>> hw/rtl/msq_pkg.sv
`default_nettype none

package msq_pkg;

   // Counter width of the sequence waits. Longer configured waits saturate.
   localparam int unsigned WAIT_WIDTH     = 20;
   localparam int unsigned CFG_LONG_WIDTH = 20;
   localparam int unsigned CFG_SHORT_WIDTH = 10;
   localparam int unsigned PIN_COUNT      = 6;

   localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_WIDTH) - 33'd1;

   // Operation codes of an input item.
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_POWER_ON  = 3'd1;
   localparam logic [2:0] OP_POWER_OFF = 3'd2;
   localparam logic [2:0] OP_RESET     = 3'd3;
   localparam logic [2:0] OP_BOOT_ON   = 3'd4;
   localparam logic [2:0] OP_BOOT_OFF  = 3'd5;
   localparam logic [2:0] OP_EVENT     = 3'd6;

   // Wired-pin mask bits.
   localparam logic [5:0] HAVE_CP_ON    = 6'd1;
   localparam logic [5:0] HAVE_CP_RESET = 6'd2;
   localparam logic [5:0] HAVE_REQ_N    = 6'd4;
   localparam logic [5:0] HAVE_UART     = 6'd8;
   localparam logic [5:0] HAVE_ACTIVE   = 6'd16;
   localparam logic [5:0] HAVE_DUMP     = 6'd32;

   // Driven pin positions.
   localparam int unsigned PIN_CP_ON    = 0;
   localparam int unsigned PIN_CP_RESET = 1;
   localparam int unsigned PIN_REQ_N    = 2;
   localparam int unsigned PIN_PDA      = 3;
   localparam int unsigned PIN_UART     = 4;
   localparam int unsigned PIN_BIAS     = 5;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;

   // Tracked modem states and reported states.
   localparam logic [1:0] TRACK_OFFLINE     = 2'd0;
   localparam logic [1:0] TRACK_BOOTING     = 2'd1;
   localparam logic [1:0] REPORT_OFFLINE    = 2'd0;
   localparam logic [1:0] REPORT_BOOTING    = 2'd1;
   localparam logic [1:0] REPORT_CRASH_RST  = 2'd2;
   localparam logic [1:0] REPORT_CRASH_EXIT = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PINS_PRESENT    = 3'd0;
   localparam logic [2:0] CSR_BIAS_PRESENT    = 3'd1;
   localparam logic [2:0] CSR_STEP_WAIT       = 3'd2;
   localparam logic [2:0] CSR_BOOT_HOLD       = 3'd3;
   localparam logic [2:0] CSR_PULSE_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_SETTLE          = 3'd5;
   localparam logic [2:0] CSR_REQUEST_WAIT    = 3'd6;

   // Configuration reset values.
   localparam logic [5:0]                 RST_PINS_PRESENT = 6'd63;
   localparam logic [CFG_SHORT_WIDTH-1:0] RST_STEP_WAIT    = 10'd160;
   localparam logic [CFG_LONG_WIDTH-1:0]  RST_BOOT_HOLD    = 20'd500000;
   localparam logic [CFG_SHORT_WIDTH-1:0] RST_PULSE_WIDTH  = 10'd60;
   localparam logic [CFG_LONG_WIDTH-1:0]  RST_SETTLE       = 20'd20000;
   localparam logic [CFG_SHORT_WIDTH-1:0] RST_REQUEST_WAIT = 10'd100;

   typedef struct packed {
      logic [2:0] op;
      logic       phone_active_level;
      logic       dump_level;
   } req_type;

   typedef struct packed {
      logic [PIN_COUNT-1:0] pins;
      logic                 busy_res;
      logic [1:0]           status;
      logic [1:0]           modem_state;
      logic                 report_valid;
      logic [1:0]           report_state;
      logic                 terminate_link;
      logic                 wait_active_low;
   } rsp_type;

   typedef struct packed {
      logic [5:0]                 pins_present;
      logic                       bias_control_present;
      logic [CFG_SHORT_WIDTH-1:0] step_wait_us;
      logic [CFG_LONG_WIDTH-1:0]  boot_hold_us;
      logic [CFG_SHORT_WIDTH-1:0] pulse_width_us;
      logic [CFG_LONG_WIDTH-1:0]  settle_us;
      logic [CFG_SHORT_WIDTH-1:0] request_wait_us;
   } cfg_type;

   // A classified command as it travels from the front to the back.
   typedef struct packed {
      logic [2:0] op;
      logic       phone_active_level;
      logic       dump_level;
      logic       missing;
      logic       is_command;
   } cmd_type;

   // Clamp a configured wait to the counter width.
   function automatic logic [WAIT_WIDTH-1:0] sat_wait(input logic [CFG_LONG_WIDTH-1:0] us);
      logic [32:0] wide;
      wide = {{(33 - CFG_LONG_WIDTH){1'b0}}, us};
      if (wide > WAIT_MAX) begin
         return WAIT_MAX[WAIT_WIDTH-1:0];
      end
      return wide[WAIT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/msq_front.sv
`default_nettype none

module msq_front (
   input  msq_pkg::req_type cmd_req,
   input  logic [5:0]       pins_present,
   output msq_pkg::cmd_type cmd_out
);
   import msq_pkg::*;

   logic [5:0] need;

   // Pins each operation depends on; a tick and the unused code need none.
   always_comb begin
      unique case (cmd_req.op) inside
         OP_POWER_ON:              need = HAVE_CP_ON | HAVE_CP_RESET | HAVE_REQ_N;
         OP_POWER_OFF:             need = HAVE_CP_ON | HAVE_CP_RESET;
         OP_RESET:                 need = HAVE_CP_RESET | HAVE_REQ_N;
         OP_BOOT_ON, OP_BOOT_OFF:  need = HAVE_UART;
         OP_EVENT:                 need = HAVE_CP_RESET | HAVE_ACTIVE | HAVE_DUMP;
         default:                  need = '0;
      endcase
   end

   always_comb begin
      cmd_out.op                 = cmd_req.op;
      cmd_out.phone_active_level = cmd_req.phone_active_level;
      cmd_out.dump_level         = cmd_req.dump_level;
      cmd_out.missing            = (pins_present & need) != need;
      cmd_out.is_command         = (cmd_req.op >= OP_POWER_ON) && (cmd_req.op <= OP_BOOT_OFF);
   end

endmodule

`default_nettype wire

>>> hw/rtl/msq_cmd_queue.sv
`default_nettype none

module msq_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msq_pkg::cmd_type push_data,
   output logic             full,
   output logic             valid,
   output msq_pkg::cmd_type pop_data,
   input  logic             pop
);
   import msq_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_push;
   logic       do_pop;

   assign full     = cnt_ff == 2'd2;
   assign valid    = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ff] <= push_data;
            wr_ff         <= ~wr_ff;
         end
         if (do_pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/msq_back.sv
`default_nettype none

module msq_back (
   input  logic             clock,
   input  logic             reset,
   input  msq_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  msq_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   output msq_pkg::rsp_type rsp_data,
   input  logic             rsp_pop
);
   import msq_pkg::*;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ON,
      KIND_RESET
   } kind_type;

   typedef struct packed {
      logic [PIN_COUNT-1:0]  pins;
      kind_type              kind;
      logic [3:0]            step;
      logic [WAIT_WIDTH-1:0] wait_cnt;
      logic [1:0]            tracked;
   } seq_type;

   // A power-on sequence has seven steps, the longest run of zero waits.
   localparam int unsigned MAX_CHAIN = 7;

   seq_type    seq_ff;
   seq_type    seq_in;
   logic       wp_ff;
   logic       wp_in;
   rsp_type    res_in;
   rsp_type    res_mem_ff [2];
   logic       res_wr_ff;
   logic       res_rd_ff;
   logic [1:0] res_cnt_ff;
   logic [1:0] res_cnt_in;
   logic       exec;
   logic       do_pop;

   function automatic seq_type load_wait(input seq_type s, input logic [CFG_LONG_WIDTH-1:0] us);
      seq_type n;
      n          = s;
      n.wait_cnt = sat_wait(us);
      n.step     = s.step + 4'd1;
      return n;
   endfunction

   function automatic seq_type finish(input seq_type s, input cfg_type c);
      seq_type n;
      n = s;
      if (c.bias_control_present) begin
         n.pins[PIN_BIAS] = 1'b0;
      end
      n.tracked  = TRACK_BOOTING;
      n.kind     = KIND_NONE;
      n.step     = 4'd0;
      n.wait_cnt = '0;
      return n;
   endfunction

   function automatic seq_type do_step(input seq_type s, input cfg_type c);
      seq_type                   n;
      logic [CFG_LONG_WIDTH-1:0] step_w;
      logic [CFG_LONG_WIDTH-1:0] pulse_w;
      logic [CFG_LONG_WIDTH-1:0] req_w;
      n       = s;
      step_w  = {{(CFG_LONG_WIDTH - CFG_SHORT_WIDTH){1'b0}}, c.step_wait_us};
      pulse_w = {{(CFG_LONG_WIDTH - CFG_SHORT_WIDTH){1'b0}}, c.pulse_width_us};
      req_w   = {{(CFG_LONG_WIDTH - CFG_SHORT_WIDTH){1'b0}}, c.request_wait_us};
      if (s.kind == KIND_ON) begin
         unique case (s.step)
            4'd0: begin
               if (c.bias_control_present) begin
                  n.pins[PIN_BIAS] = 1'b1;
               end
               n.pins[PIN_CP_ON]    = 1'b0;
               n.pins[PIN_CP_RESET] = 1'b0;
               n = load_wait(n, step_w);
            end
            4'd1: begin
               n.pins[PIN_PDA] = 1'b0;
               n = load_wait(n, c.boot_hold_us);
            end
            4'd2: begin
               n.pins[PIN_CP_RESET] = 1'b1;
               n = load_wait(n, step_w);
            end
            4'd3: begin
               n.pins[PIN_REQ_N] = 1'b1;
               n = load_wait(n, step_w);
            end
            4'd4: begin
               n.pins[PIN_CP_ON] = 1'b1;
               n = load_wait(n, pulse_w);
            end
            4'd5: begin
               n.pins[PIN_CP_ON] = 1'b0;
               n = load_wait(n, c.settle_us);
            end
            default: begin
               n.pins[PIN_PDA] = 1'b1;
               n = finish(n, c);
            end
         endcase
      end else if (s.kind == KIND_RESET) begin
         unique case (s.step)
            4'd0: begin
               if (c.bias_control_present) begin
                  n.pins[PIN_BIAS] = 1'b1;
               end
               n.pins[PIN_CP_RESET] = 1'b0;
               n.pins[PIN_REQ_N]    = 1'b0;
               n.tracked            = TRACK_OFFLINE;
               n = load_wait(n, c.settle_us);
            end
            4'd1: begin
               n.pins[PIN_CP_RESET] = 1'b1;
               n = load_wait(n, step_w);
            end
            4'd2: begin
               n.pins[PIN_REQ_N] = 1'b1;
               n = load_wait(n, req_w);
            end
            4'd3: begin
               n.pins[PIN_CP_ON] = 1'b1;
               n = load_wait(n, pulse_w);
            end
            4'd4: begin
               n.pins[PIN_CP_ON] = 1'b0;
               n = load_wait(n, c.settle_us);
            end
            default: begin
               n = finish(n, c);
            end
         endcase
      end
      return n;
   endfunction

   // Steps whose wait has run out follow one another within the same item.
   function automatic seq_type run_steps(input seq_type s, input cfg_type c);
      seq_type r;
      r = s;
      for (int i = 0; i < MAX_CHAIN; i++) begin
         if (r.kind != KIND_NONE && r.wait_cnt == '0) begin
            r = do_step(r, c);
         end
      end
      return r;
   endfunction

   assign exec      = cmd_valid && (res_cnt_ff != 2'd2);
   assign cmd_pop   = exec;
   assign rsp_empty = res_cnt_ff == 2'd0;
   assign rsp_data  = res_mem_ff[res_rd_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      logic    busy;
      seq_type s;
      busy = seq_ff.kind != KIND_NONE;
      s    = seq_ff;
      wp_in = wp_ff;
      res_in                = '0;
      res_in.status         = ST_OK;
      res_in.report_state   = REPORT_OFFLINE;
      if (cmd.missing) begin
         res_in.status = ST_MISSING;
      end else if (cmd.is_command && busy) begin
         res_in.status = ST_BUSY;
      end else begin
         unique case (cmd.op) inside
            OP_TICK: begin
               if (busy) begin
                  if (s.wait_cnt != '0) begin
                     s.wait_cnt = s.wait_cnt - WAIT_WIDTH'(1);
                  end
                  s = run_steps(s, cfg);
               end
            end
            OP_POWER_ON, OP_RESET: begin
               s.kind     = (cmd.op == OP_POWER_ON) ? KIND_ON : KIND_RESET;
               s.step     = 4'd0;
               s.wait_cnt = '0;
               s = run_steps(s, cfg);
            end
            OP_POWER_OFF: begin
               s.pins[PIN_CP_ON]    = 1'b0;
               s.pins[PIN_CP_RESET] = 1'b0;
               s.tracked            = TRACK_OFFLINE;
            end
            OP_BOOT_ON, OP_BOOT_OFF: begin
               s.pins[PIN_UART] = cmd.op == OP_BOOT_OFF;
            end
            OP_EVENT: begin
               // The driven cp_reset level stands for the sensed reset line.
               if (seq_ff.pins[PIN_CP_RESET] && cmd.phone_active_level) begin
                  res_in.report_valid = 1'b1;
                  res_in.report_state = REPORT_BOOTING;
               end else if (seq_ff.pins[PIN_CP_RESET]) begin
                  if (seq_ff.tracked != TRACK_BOOTING) begin
                     res_in.report_valid   = 1'b1;
                     res_in.report_state   = cmd.dump_level ? REPORT_CRASH_EXIT
                                                            : REPORT_CRASH_RST;
                     res_in.terminate_link = 1'b1;
                  end
               end else begin
                  res_in.report_valid = 1'b1;
                  res_in.report_state = REPORT_OFFLINE;
               end
               wp_in = cmd.phone_active_level;
            end
            default: begin
            end
         endcase
      end
      seq_in                 = s;
      res_in.pins            = s.pins;
      res_in.busy_res        = s.kind != KIND_NONE;
      res_in.modem_state     = s.tracked;
      res_in.wait_active_low = wp_in;
   end

   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (exec && !do_pop) begin
         res_cnt_in = res_cnt_ff + 2'd1;
      end else if (do_pop && !exec) begin
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= '{pins: '0, kind: KIND_NONE, step: 4'd0, wait_cnt: '0,
                         tracked: TRACK_OFFLINE};
         wp_ff      <= 1'b0;
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         if (exec) begin
            seq_ff                <= seq_in;
            wp_ff                 <= wp_in;
            res_mem_ff[res_wr_ff] <= res_in;
            res_wr_ff             <= ~res_wr_ff;
         end
         if (do_pop) begin
            res_rd_ff <= ~res_rd_ff;
         end
         res_cnt_ff <= res_cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/modem_power_sequencer.sv
// Modem power sequencer: drives the power, reset and boot pins of a cellular modem.
// Input channel: an item (op, phone_active_level, dump_level) transfers at a clock edge
// with req_push high and req_full low. A tick item stands for one microsecond of time.
// Result channel: the oldest result sits on rsp_data while rsp_empty is low and
// transfers at a clock edge with rsp_pop high. Every input item yields one result.
// Configuration: csr_we writes csr_wdata into the register chosen by csr_index at once;
// write only while no item is in flight.
// Throughput is one item per cycle while the result queue has room: the back end makes
// a single update of the sequence state per item, and zero-wait steps complete within it.
// A result reaches rsp_data once the back end has executed its item from the registered
// command queue into the registered result queue; the back end holds items while the
// result queue is full.
// Reset clears the sequence, drives all pins low, sets the tracked state offline and
// loads the default register values; both queues start empty.
// When the receiver stalls, the two-entry result queue fills, then the two-entry
// command queue, and req_full rises; nothing is dropped and work resumes on pop.

`default_nettype none

module modem_power_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  msq_pkg::req_type          req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   output msq_pkg::rsp_type          rsp_data,
   input  logic                      rsp_pop,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [msq_pkg::CFG_LONG_WIDTH-1:0] csr_wdata
);
   import msq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   cmd_type cmd_class;
   cmd_type cmd_head;
   logic    cmd_valid;
   logic    cmd_pop;

   // Register file update; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PINS_PRESENT: cfg_in.pins_present         = csr_wdata[5:0];
            CSR_BIAS_PRESENT: cfg_in.bias_control_present = csr_wdata[0];
            CSR_STEP_WAIT:    cfg_in.step_wait_us    = csr_wdata[CFG_SHORT_WIDTH-1:0];
            CSR_BOOT_HOLD:    cfg_in.boot_hold_us    = csr_wdata;
            CSR_PULSE_WIDTH:  cfg_in.pulse_width_us  = csr_wdata[CFG_SHORT_WIDTH-1:0];
            CSR_SETTLE:       cfg_in.settle_us       = csr_wdata;
            CSR_REQUEST_WAIT: cfg_in.request_wait_us = csr_wdata[CFG_SHORT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pins_present: RST_PINS_PRESENT, bias_control_present: 1'b0,
                     step_wait_us: RST_STEP_WAIT, boot_hold_us: RST_BOOT_HOLD,
                     pulse_width_us: RST_PULSE_WIDTH, settle_us: RST_SETTLE,
                     request_wait_us: RST_REQUEST_WAIT};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end tags each item with its missing-pin verdict and command class.
   msq_front u_front (
      .cmd_req      (req_data),
      .pins_present (cfg_ff.pins_present),
      .cmd_out      (cmd_class)
   );

   // A short queue lets the front keep taking items while the back end stalls.
   msq_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_class),
      .full      (req_full),
      .valid     (cmd_valid),
      .pop_data  (cmd_head),
      .pop       (cmd_pop)
   );

   // The back end owns the pin and sequence state and buffers the results.
   msq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   // Both queues come out of reset empty.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A status code is never outside the three defined ones.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status == ST_OK || rsp_data.status == ST_MISSING ||
                      rsp_data.status == ST_BUSY))
      else $error("undefined status code");

   // Link termination comes only with a crash report.
   a_terminate_crash: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.terminate_link |->
         rsp_data.report_valid && (rsp_data.report_state == REPORT_CRASH_RST ||
                                   rsp_data.report_state == REPORT_CRASH_EXIT))
      else $error("terminate without crash report");

   // A refused item carries no report.
   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != ST_OK |-> !rsp_data.report_valid &&
         rsp_data.report_state == REPORT_OFFLINE && !rsp_data.terminate_link)
      else $error("report on a refused item");

endmodule

`default_nettype wire

>>> bench/modem_power_sequencer_tb.sv
module modem_power_sequencer_tb;
   import msq_pkg::*;

   // The spare operation code; the block answers it with an accepted status and no effect.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int QUIET_LIMIT = 5000;

   typedef enum logic [1:0] {
      SEQ_NONE     = 2'd0,
      SEQ_POWER_ON = 2'd1,
      SEQ_RESET    = 2'd2
   } seq_kind_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // The tracker mirrors the sequencer: its registers, its pins, the running sequence and
   // the wait counter. Every accepted command is played on it at once, and the outcome it
   // predicts waits in a queue until the block hands over the matching result.
   class sequencer_tracker_type;
      logic [5:0]            wired;
      logic                  bias_ctl;
      logic [9:0]            step_us;
      logic [19:0]           hold_us;
      logic [9:0]            pulse_us;
      logic [19:0]           settle_us;
      logic [9:0]            request_us;

      logic [5:0]            pin_lvl;
      seq_kind_type          seq_kind;
      logic [3:0]            seq_step;
      logic [WAIT_WIDTH-1:0] wait_left;
      logic [1:0]            tracked;
      logic                  polarity;

      rsp_type               pending[$];

      int unsigned mismatches;
      int unsigned checked;
      int unsigned power_ons_done;
      int unsigned resets_done;
      int unsigned crash_reports;
      int unsigned busy_refusals;
      int unsigned missing_refusals;

      function new();
         wired      = RST_PINS_PRESENT;
         bias_ctl   = 1'b0;
         step_us    = RST_STEP_WAIT;
         hold_us    = RST_BOOT_HOLD;
         pulse_us   = RST_PULSE_WIDTH;
         settle_us  = RST_SETTLE;
         request_us = RST_REQUEST_WAIT;
         pin_lvl    = '0;
         seq_kind   = SEQ_NONE;
         seq_step   = '0;
         wait_left  = '0;
         tracked    = TRACK_OFFLINE;
         polarity   = 1'b0;
      endfunction

      function logic [19:0] field_mask(logic [2:0] idx);
         case (idx) inside
            CSR_PINS_PRESENT: return 20'h0003F;
            CSR_BIAS_PRESENT: return 20'h00001;
            CSR_BOOT_HOLD, CSR_SETTLE: return 20'hFFFFF;
            default: return 20'h003FF;
         endcase
      endfunction

      function void set_register(logic [2:0] idx, logic [19:0] value);
         logic [19:0] kept;
         kept = value & field_mask(idx);
         case (idx)
            CSR_PINS_PRESENT: wired      = kept[5:0];
            CSR_BIAS_PRESENT: bias_ctl   = kept[0];
            CSR_STEP_WAIT:    step_us    = kept[9:0];
            CSR_BOOT_HOLD:    hold_us    = kept;
            CSR_PULSE_WIDTH:  pulse_us   = kept[9:0];
            CSR_SETTLE:       settle_us  = kept;
            CSR_REQUEST_WAIT: request_us = kept[9:0];
            default: ;
         endcase
      endfunction

      // Arm the wait before the next step; anything beyond the counter saturates.
      function void load_wait(logic [19:0] us);
         if (33'(us) > WAIT_MAX) begin
            wait_left = '1;
         end else begin
            wait_left = WAIT_WIDTH'(us);
         end
         seq_step = seq_step + 4'd1;
      endfunction

      function void end_sequence();
         if (bias_ctl) begin
            pin_lvl[PIN_BIAS] = 1'b0;
         end
         if (seq_kind == SEQ_POWER_ON) begin
            power_ons_done++;
         end else begin
            resets_done++;
         end
         tracked   = TRACK_BOOTING;
         seq_kind  = SEQ_NONE;
         seq_step  = '0;
         wait_left = '0;
      endfunction

      function void advance();
         case (seq_kind)
            SEQ_POWER_ON: begin
               case (seq_step)
                  4'd0: begin
                     if (bias_ctl) begin
                        pin_lvl[PIN_BIAS] = 1'b1;
                     end
                     pin_lvl[PIN_CP_ON]    = 1'b0;
                     pin_lvl[PIN_CP_RESET] = 1'b0;
                     load_wait(20'(step_us));
                  end
                  4'd1: begin
                     pin_lvl[PIN_PDA] = 1'b0;
                     load_wait(hold_us);
                  end
                  4'd2: begin
                     pin_lvl[PIN_CP_RESET] = 1'b1;
                     load_wait(20'(step_us));
                  end
                  4'd3: begin
                     pin_lvl[PIN_REQ_N] = 1'b1;
                     load_wait(20'(step_us));
                  end
                  4'd4: begin
                     pin_lvl[PIN_CP_ON] = 1'b1;
                     load_wait(20'(pulse_us));
                  end
                  4'd5: begin
                     pin_lvl[PIN_CP_ON] = 1'b0;
                     load_wait(settle_us);
                  end
                  default: begin
                     pin_lvl[PIN_PDA] = 1'b1;
                     end_sequence();
                  end
               endcase
            end
            SEQ_RESET: begin
               case (seq_step)
                  4'd0: begin
                     if (bias_ctl) begin
                        pin_lvl[PIN_BIAS] = 1'b1;
                     end
                     pin_lvl[PIN_CP_RESET] = 1'b0;
                     pin_lvl[PIN_REQ_N]    = 1'b0;
                     tracked = TRACK_OFFLINE;
                     load_wait(settle_us);
                  end
                  4'd1: begin
                     pin_lvl[PIN_CP_RESET] = 1'b1;
                     load_wait(20'(step_us));
                  end
                  4'd2: begin
                     pin_lvl[PIN_REQ_N] = 1'b1;
                     load_wait(20'(request_us));
                  end
                  4'd3: begin
                     pin_lvl[PIN_CP_ON] = 1'b1;
                     load_wait(20'(pulse_us));
                  end
                  4'd4: begin
                     pin_lvl[PIN_CP_ON] = 1'b0;
                     load_wait(settle_us);
                  end
                  default: end_sequence();
               endcase
            end
            default: begin
               seq_kind  = SEQ_NONE;
               seq_step  = '0;
               wait_left = '0;
            end
         endcase
      endfunction

      // Steps whose wait has run out follow each other within the same item.
      function void run_ready_steps();
         for (int guard = 0; guard < 16; guard++) begin
            if (seq_kind == SEQ_NONE || wait_left != '0) begin
               break;
            end
            advance();
         end
      endfunction

      function rsp_type predict(req_type cmd);
         rsp_type    outcome;
         logic [5:0] need;
         logic       busy;
         outcome = '0;
         busy    = (seq_kind != SEQ_NONE);
         case (cmd.op) inside
            OP_POWER_ON:             need = HAVE_CP_ON | HAVE_CP_RESET | HAVE_REQ_N;
            OP_POWER_OFF:            need = HAVE_CP_ON | HAVE_CP_RESET;
            OP_RESET:                need = HAVE_CP_RESET | HAVE_REQ_N;
            OP_BOOT_ON, OP_BOOT_OFF: need = HAVE_UART;
            OP_EVENT:                need = HAVE_CP_RESET | HAVE_ACTIVE | HAVE_DUMP;
            default:                 need = '0;
         endcase
         outcome.status = ST_OK;
         if ((wired & need) != need) begin
            // A missing pin wins over a running sequence.
            outcome.status = ST_MISSING;
            missing_refusals++;
         end else if (cmd.op >= OP_POWER_ON && cmd.op <= OP_BOOT_OFF && busy) begin
            outcome.status = ST_BUSY;
            busy_refusals++;
         end else begin
            case (cmd.op) inside
               OP_TICK: begin
                  if (busy) begin
                     if (wait_left != '0) begin
                        wait_left = wait_left - 1'b1;
                     end
                     run_ready_steps();
                  end
               end
               OP_POWER_ON, OP_RESET: begin
                  seq_kind  = (cmd.op == OP_POWER_ON) ? SEQ_POWER_ON : SEQ_RESET;
                  seq_step  = '0;
                  wait_left = '0;
                  run_ready_steps();
               end
               OP_POWER_OFF: begin
                  pin_lvl[PIN_CP_ON]    = 1'b0;
                  pin_lvl[PIN_CP_RESET] = 1'b0;
                  tracked = TRACK_OFFLINE;
               end
               OP_BOOT_ON, OP_BOOT_OFF: pin_lvl[PIN_UART] = (cmd.op == OP_BOOT_OFF);
               OP_EVENT: begin
                  // The driven cp_reset level stands for the sensed reset line.
                  if (pin_lvl[PIN_CP_RESET] && cmd.phone_active_level) begin
                     outcome.report_valid = 1'b1;
                     outcome.report_state = REPORT_BOOTING;
                  end else if (pin_lvl[PIN_CP_RESET]) begin
                     if (tracked != TRACK_BOOTING) begin
                        outcome.report_valid   = 1'b1;
                        outcome.report_state   = cmd.dump_level ? REPORT_CRASH_EXIT
                                                                : REPORT_CRASH_RST;
                        outcome.terminate_link = 1'b1;
                        crash_reports++;
                     end
                  end else begin
                     outcome.report_valid = 1'b1;
                     outcome.report_state = REPORT_OFFLINE;
                  end
                  polarity = cmd.phone_active_level;
               end
               default: ;
            endcase
         end
         outcome.pins            = pin_lvl;
         outcome.busy_res        = (seq_kind != SEQ_NONE);
         outcome.modem_state     = tracked;
         outcome.wait_active_low = polarity;
         return outcome;
      endfunction

      function void take_command(req_type cmd);
         pending.push_back(predict(cmd));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         mismatches++;
         $display("mismatch at %0t, result %0d: %s is %0h, should be %0h",
                  $time, checked, what, got, want);
      endtask

      task compare_outcome(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("result with no command waiting", got, 0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.pins !== want.pins)
            report_mismatch("pins", got.pins, want.pins);
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         if (got.modem_state !== want.modem_state)
            report_mismatch("modem_state", got.modem_state, want.modem_state);
         if (got.report_valid !== want.report_valid)
            report_mismatch("report_valid", got.report_valid, want.report_valid);
         if (got.report_state !== want.report_state)
            report_mismatch("report_state", got.report_state, want.report_state);
         if (got.terminate_link !== want.terminate_link)
            report_mismatch("terminate_link", got.terminate_link, want.terminate_link);
         if (got.wait_active_low !== want.wait_active_low)
            report_mismatch("wait_active_low", got.wait_active_low, want.wait_active_low);
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   req_type                   req_data;
   logic                      req_full;
   logic                      rsp_empty;
   rsp_type                   rsp_data;
   logic                      rsp_pop;
   logic                      csr_we;
   logic [2:0]                csr_index;
   logic [CFG_LONG_WIDTH-1:0] csr_wdata;

   sequencer_tracker_type tracker;

   // Register values for the next setting, indexed by register index.
   logic [19:0] setting [0:6];

   int unsigned push_idle_pct;
   int unsigned pop_stall_pct;
   int          hold_span;
   int          quiet_cycles;
   int unsigned commands_sent;
   int unsigned settings_applied;

   modem_power_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Result side. The pop level and the result seen right after an edge are the values
   // the block saw at that edge, so a transfer is judged exactly as the block judges it.
   // A pending hold-off keeps pop low while it counts down, whatever the idle mode says.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            tracker.compare_outcome(rsp_data);
         end
         if (hold_span > 0) begin
            hold_span = hold_span - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
         end
      end
   end

   // Watchdog: a healthy run never goes this long without a transfer or a register write.
   always @(posedge clock) begin
      if (reset || csr_we || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("modem_power_sequencer_tb NOT OK");
         $finish;
      end
   end

   function automatic void set_idle_mode(idle_mode_type mode);
      push_idle_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 11 : 0;
      pop_stall_pct = (mode == IDLE_RECEIVER) ? 80 : (mode == IDLE_BOTH) ? 11 : 0;
   endfunction

   // Ticks dominate so that sequences get through their waits; events are frequent
   // enough to sample every stage of a sequence.
   function automatic logic [2:0] pick_op();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 52) return OP_TICK;
      if (roll < 59) return OP_POWER_ON;
      if (roll < 63) return OP_POWER_OFF;
      if (roll < 70) return OP_RESET;
      if (roll < 74) return OP_BOOT_ON;
      if (roll < 78) return OP_BOOT_OFF;
      if (roll < 97) return OP_EVENT;
      return OP_UNUSED;
   endfunction

   // A random sensed pin level.
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Offers one command and returns at the edge where it transfers. The sender idles at
   // random before the offer, and push stays high across back-to-back commands.
   task automatic send_item(logic [2:0] op, logic pa, logic dump);
      req_type cmd;
      cmd = {op, pa, dump};
      while ($urandom_range(0, 99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      tracker.take_command(cmd);
      commands_sent++;
   endtask

   // Lets the current sequence run out, with a rare event mixed in.
   task automatic tick_until_quiet();
      while (tracker.seq_kind != SEQ_NONE) begin
         send_item(($urandom_range(0, 39) == 0) ? OP_EVENT : OP_TICK, coin(), coin());
      end
   endtask

   // Stops offering and waits until every predicted result has been handed over.
   task automatic wait_until_drained();
      req_push <= 1'b0;
      while (tracker.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // One register write; bits above the register's width carry random junk now and then,
   // which the block has to drop.
   task automatic write_csr(logic [2:0] idx);
      logic [19:0] wdata;
      wdata = setting[idx] & tracker.field_mask(idx);
      if ($urandom_range(0, 1) == 1) begin
         wdata = wdata | (20'($urandom) & ~tracker.field_mask(idx));
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      tracker.set_register(idx, wdata);
   endtask

   task automatic apply_settings();
      wait_until_drained();
      write_csr(CSR_PINS_PRESENT);
      write_csr(CSR_BIAS_PRESENT);
      write_csr(CSR_STEP_WAIT);
      write_csr(CSR_BOOT_HOLD);
      write_csr(CSR_PULSE_WIDTH);
      write_csr(CSR_SETTLE);
      write_csr(CSR_REQUEST_WAIT);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // Short waits keep whole sequences inside one phase. Most settings wire every pin;
   // the rest pull random pins so that missing-pin refusals show up in every command.
   function automatic void roll_settings();
      setting[CSR_PINS_PRESENT] = ($urandom_range(0, 2) == 0) ? 20'($urandom_range(0, 63))
                                                              : 20'd63;
      setting[CSR_BIAS_PRESENT] = 20'($urandom_range(0, 1));
      setting[CSR_STEP_WAIT]    = 20'($urandom_range(0, 3));
      setting[CSR_BOOT_HOLD]    = 20'($urandom_range(0, 12));
      setting[CSR_PULSE_WIDTH]  = 20'($urandom_range(0, 3));
      setting[CSR_SETTLE]       = 20'($urandom_range(0, 12));
      setting[CSR_REQUEST_WAIT] = 20'($urandom_range(0, 3));
   endfunction

   initial begin
      tracker          = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_data         = '0;
      rsp_pop          = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_PINS_PRESENT;
      csr_wdata        = '0;
      hold_span        = 0;
      quiet_cycles     = 0;
      commands_sent    = 0;
      settings_applied = 0;
      set_idle_mode(IDLE_NONE);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: the default waits are far too long to run a sequence through, so
      // only the commands that act at once and the events with cp_reset still low.
      send_item(OP_BOOT_ON, 1'b0, 1'b0);
      send_item(OP_BOOT_OFF, 1'b1, 1'b1);
      send_item(OP_EVENT, 1'b0, 1'b0);
      send_item(OP_EVENT, 1'b1, 1'b0);
      send_item(OP_EVENT, 1'b0, 1'b1);
      send_item(OP_EVENT, 1'b1, 1'b1);
      send_item(OP_POWER_OFF, 1'b0, 1'b0);
      send_item(OP_UNUSED, 1'b1, 1'b1);
      send_item(OP_TICK, 1'b0, 1'b0);

      // Short waits with bias control: a reset sequence walks cp_reset low, then high
      // while the tracked state is still offline, which is where crashes are reported.
      setting[CSR_PINS_PRESENT] = 20'd63;
      setting[CSR_BIAS_PRESENT] = 20'd1;
      setting[CSR_STEP_WAIT]    = 20'd2;
      setting[CSR_BOOT_HOLD]    = 20'd3;
      setting[CSR_PULSE_WIDTH]  = 20'd1;
      setting[CSR_SETTLE]       = 20'd4;
      setting[CSR_REQUEST_WAIT] = 20'd2;
      apply_settings();
      send_item(OP_RESET, 1'b0, 1'b0);
      send_item(OP_EVENT, 1'b0, 1'b1);
      repeat (4) send_item(OP_TICK, 1'b0, 1'b0);
      send_item(OP_EVENT, 1'b0, 1'b1);
      send_item(OP_EVENT, 1'b0, 1'b0);
      send_item(OP_POWER_ON, 1'b0, 1'b0);
      send_item(OP_BOOT_ON, 1'b0, 1'b0);
      tick_until_quiet();
      // Booting now: an active-high event reports booting, an active-low one nothing.
      send_item(OP_EVENT, 1'b1, 1'b0);
      send_item(OP_EVENT, 1'b0, 1'b1);
      send_item(OP_POWER_OFF, 1'b0, 1'b0);
      send_item(OP_POWER_ON, 1'b1, 1'b0);
      tick_until_quiet();

      // No pin wired: every command and the event are refused for a missing pin.
      setting[CSR_PINS_PRESENT] = 20'd0;
      apply_settings();
      send_item(OP_POWER_ON, 1'b0, 1'b0);
      send_item(OP_RESET, 1'b0, 1'b0);
      send_item(OP_POWER_OFF, 1'b0, 1'b0);
      send_item(OP_BOOT_ON, 1'b0, 1'b0);
      send_item(OP_BOOT_OFF, 1'b0, 1'b0);
      send_item(OP_EVENT, 1'b1, 1'b1);

      // Random phases, each with its own setting, cycling through the idle modes. The
      // first one also holds the receiver off for a long stretch so that both queues fill
      // and req_full pushes back, and halfway through it the sender waits for the drain.
      for (int phase = 0; phase < 8; phase++) begin
         roll_settings();
         apply_settings();
         set_idle_mode(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            hold_span = 250;
         end
         for (int n = 0; n < 70; n++) begin
            if (phase == 0 && n == 35) begin
               wait_until_drained();
            end
            send_item(pick_op(), coin(), coin());
         end
      end

      // All waits zero: a whole sequence completes within the command that starts it.
      tick_until_quiet();
      setting[CSR_PINS_PRESENT] = 20'd63;
      setting[CSR_BIAS_PRESENT] = 20'd1;
      setting[CSR_STEP_WAIT]    = 20'd0;
      setting[CSR_BOOT_HOLD]    = 20'd0;
      setting[CSR_PULSE_WIDTH]  = 20'd0;
      setting[CSR_SETTLE]       = 20'd0;
      setting[CSR_REQUEST_WAIT] = 20'd0;
      apply_settings();
      set_idle_mode(IDLE_BOTH);
      for (int n = 0; n < 80; n++) begin
         send_item(pick_op(), coin(), coin());
      end

      // The step wait at its maximum: one full reset sequence.
      setting[CSR_BIAS_PRESENT] = 20'd0;
      setting[CSR_STEP_WAIT]    = 20'd1023;
      setting[CSR_BOOT_HOLD]    = 20'd5;
      setting[CSR_PULSE_WIDTH]  = 20'd1;
      setting[CSR_SETTLE]       = 20'd3;
      setting[CSR_REQUEST_WAIT] = 20'd2;
      apply_settings();
      set_idle_mode(IDLE_NONE);
      send_item(OP_RESET, 1'b1, 1'b0);
      tick_until_quiet();

      // The long registers at their maximum: the power-on sequence loads the full boot
      // hold and stays busy for the rest of the run, so commands are refused from here on.
      setting[CSR_BIAS_PRESENT] = 20'd1;
      setting[CSR_STEP_WAIT]    = 20'd0;
      setting[CSR_BOOT_HOLD]    = 20'hFFFFF;
      setting[CSR_SETTLE]       = 20'hFFFFF;
      apply_settings();
      set_idle_mode(IDLE_RECEIVER);
      send_item(OP_POWER_ON, 1'b0, 1'b0);
      for (int n = 0; n < 60; n++) begin
         send_item(pick_op(), coin(), coin());
      end

      wait_until_drained();
      repeat (10) @(posedge clock);

      $display("%0d command transfers, %0d results checked under %0d register settings.",
               commands_sent, tracker.checked, settings_applied);
      $display("%0d power-on and %0d reset sequences ran out, %0d crash reports, %0d busy %s",
               tracker.power_ons_done, tracker.resets_done, tracker.crash_reports,
               tracker.busy_refusals, "refusals.");
      if (tracker.mismatches == 0) begin
         $display("modem_power_sequencer_tb OK");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("modem_power_sequencer_tb NOT OK");
      end
      $finish;
   end

endmodule
